[hw/rtl/pcrt_pkg.sv]
// Shared constants and types for the pair contact record table.
// Used by pair_contact_record_table; depends on nothing else.
package pcrt_pkg;

    // Table depth and derived widths
    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    // Field widths at the ports
    localparam int REQ_W   = 2;
    localparam int PROC_W  = 10;
    localparam int PID_W   = 31;
    localparam int INDEX_W = 6;
    localparam int COUNT_W = 7;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_MATCH = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CHECK = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SWEEP = 2'd2;

    // One stored record: accessed mark and the two keys
    typedef struct packed {
        logic              mark;
        logic [PROC_W-1:0] proc;
        logic [PID_W-1:0]  pid;
    } entry_t;

endpackage

[hw/rtl/pair_contact_record_table.sv]
// Pair contact record table: ordered key table with match, check and sweep.
// Depends on pcrt_pkg (depth, widths, request codes, record type).
//
// Usage:
//   Input channel (in_valid/in_ready) carries one request word: req_type,
//   partner_proc, partner_id. Output channel (out_valid/out_ready) carries
//   one result word per request: hit, entry_index, table_full, record_count.
//   Records live in a single-port-write, registered-read memory that one
//   sequencer walks from position 0 upward, one entry per cycle, with a
//   single key comparator on the registered read data.
// Request handling, with n valid records:
//   match/check hit: the scan stops at the first matching record.
//   match/check miss: all n records are scanned (insert is written as the result finishes).
//   sweep: all n records are scanned; kept records are compacted in place as they stream.
//   unused request code: result valid right after the accepting
//   edge; table unchanged.
// Throughput: one request at a time.
// Reset: the record count clears to zero, no result is pending; the memory
//   is not cleared since only positions below the count are ever used.
// Stall: a finished result waits in the output register; a new request is
//   taken once that register is empty or is being drained in the same cycle.
module pair_contact_record_table (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [pcrt_pkg::REQ_W-1:0]   req_type,
    input  logic [pcrt_pkg::PROC_W-1:0]  partner_proc,
    input  logic [pcrt_pkg::PID_W-1:0]   partner_id,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         hit,
    output logic [pcrt_pkg::INDEX_W-1:0] entry_index,
    output logic                         table_full,
    output logic [pcrt_pkg::COUNT_W-1:0] record_count
);
    import pcrt_pkg::*;

    // Sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_SWEEP = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0] wr_reg, wr_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;

    // Latched request word
    logic [REQ_W-1:0]  req_reg;
    logic [PROC_W-1:0] proc_reg;
    logic [PID_W-1:0]  pid_reg;

    // Record memory
    entry_t           mem [TABLE_ENTRIES];
    entry_t           rd_q;
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    entry_t           mem_wd;
    logic [IDX_W-1:0] mem_ra;

    // Result register
    logic               out_valid_reg;
    logic               hit_reg;
    logic [INDEX_W-1:0] index_reg;
    logic               full_reg;
    logic [COUNT_W-1:0] count_out_reg;

    // Finish strobe and result fields from the sequencer
    logic             fin;
    logic             fin_hit;
    logic [IDX_W-1:0] fin_idx;
    logic             fin_full;

    logic             in_fire;
    logic             issue;
    logic             key_match;
    logic [CNT_W-1:0] wr_inc;

    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire   = in_valid && in_ready;
    assign issue     = (ptr_reg != count_reg);
    assign mem_ra    = ptr_reg[IDX_W-1:0];
    assign key_match = pend_valid_reg && (rd_q.proc == proc_reg) && (rd_q.pid == pid_reg);
    assign wr_inc    = CNT_W'(wr_reg + 1'b1);

    // Memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_q <= mem[mem_ra];
    end

    // Sequencer: walk the table one entry per cycle
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        wr_next         = wr_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        mem_we          = 1'b0;
        mem_wa          = pend_idx_reg;
        mem_wd          = rd_q;
        fin             = 1'b0;
        fin_hit         = 1'b0;
        fin_idx         = '0;
        fin_full        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    ptr_next        = '0;
                    wr_next         = '0;
                    pend_valid_next = 1'b0;
                    case (req_type) inside
                        REQ_MATCH, REQ_CHECK: state_next = ST_SCAN;
                        REQ_SWEEP:            state_next = ST_SWEEP;
                        default:              fin = 1'b1;
                    endcase
                end
            end

            ST_SCAN:
            begin
                pend_valid_next = issue;
                pend_idx_next   = ptr_reg[IDX_W-1:0];
                if (issue)
                begin
                    ptr_next = CNT_W'(ptr_reg + 1'b1);
                end
                if (key_match)
                begin
                    // first matching record: report it, mark it on a match request
                    fin        = 1'b1;
                    fin_hit    = 1'b1;
                    fin_idx    = pend_idx_reg;
                    state_next = ST_IDLE;
                    if (req_reg == REQ_MATCH)
                    begin
                        mem_we = 1'b1;
                        mem_wa = pend_idx_reg;
                        mem_wd = '{mark: 1'b1, proc: proc_reg, pid: pid_reg};
                    end
                end
                else if (!issue)
                begin
                    // no record matched
                    fin        = 1'b1;
                    state_next = ST_IDLE;
                    if (req_reg == REQ_MATCH)
                    begin
                        if (count_reg == CNT_W'(TABLE_ENTRIES))
                        begin
                            fin_full = 1'b1;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_wa     = count_reg[IDX_W-1:0];
                            mem_wd     = '{mark: 1'b1, proc: proc_reg, pid: pid_reg};
                            fin_idx    = count_reg[IDX_W-1:0];
                            count_next = CNT_W'(count_reg + 1'b1);
                        end
                    end
                end
            end

            ST_SWEEP:
            begin
                pend_valid_next = issue;
                pend_idx_next   = ptr_reg[IDX_W-1:0];
                if (issue)
                begin
                    ptr_next = CNT_W'(ptr_reg + 1'b1);
                end
                // keep marked records, packed down with marks cleared
                if (pend_valid_reg && rd_q.mark)
                begin
                    mem_we  = 1'b1;
                    mem_wa  = wr_reg[IDX_W-1:0];
                    mem_wd  = '{mark: 1'b0, proc: rd_q.proc, pid: rd_q.pid};
                    wr_next = wr_inc;
                end
                if (!issue)
                begin
                    fin        = 1'b1;
                    count_next = wr_next;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            ptr_reg        <= '0;
            wr_reg         <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ptr_reg        <= ptr_next;
            wr_reg         <= wr_next;
            pend_valid_reg <= pend_valid_next;
            if (fin)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: request latch, scan index, result word
    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        if (in_fire)
        begin
            req_reg  <= req_type;
            proc_reg <= partner_proc;
            pid_reg  <= partner_id;
        end
        if (fin)
        begin
            hit_reg       <= fin_hit;
            index_reg     <= INDEX_W'(fin_idx);
            full_reg      <= fin_full;
            count_out_reg <= COUNT_W'(count_next);
        end
    end

    assign out_valid    = out_valid_reg;
    assign hit          = hit_reg;
    assign entry_index  = index_reg;
    assign table_full   = full_reg;
    assign record_count = count_out_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("record count beyond table depth");

    a_sweep_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) |-> (wr_reg <= ptr_reg))
        else $error("sweep write position passed read position");

    a_count_report: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (state_reg == ST_IDLE)) |-> (count_out_reg == COUNT_W'(count_reg)))
        else $error("reported record count disagrees with table");

    a_full_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (fin && fin_full) |-> (!fin_hit && (req_reg == REQ_MATCH)))
        else $error("table full flagged outside a missed match");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        fin |-> (!out_valid_reg || out_ready))
        else $error("result finished while output register still held");

endmodule
